/* src/vwwa_pkg.sv */
// ----------------------------------------------------------------------------
// vwwa_pkg
// Widths, limits and reset values shared by the windowed VWAP block.
// ----------------------------------------------------------------------------
`default_nettype none

package vwwa_pkg;

  localparam int PRICE_W      = 24;
  localparam int VOLUME_W     = 32;
  localparam int PROD_W       = PRICE_W + VOLUME_W;
  localparam int PSUM_W       = 64;
  localparam int VSUM_W       = 40;
  localparam int WIN_W        = 9;
  localparam int SLOT_W       = 8;
  localparam int WINDOW_MAX   = 256;
  localparam int WINDOW_RESET = 20;
  localparam int RING_W       = PROD_W + VOLUME_W;
  localparam int DIV_CNT_W    = $clog2(PSUM_W);

  typedef logic [PRICE_W-1:0]  price_t;
  typedef logic [VOLUME_W-1:0] volume_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [PSUM_W-1:0]   psum_t;
  typedef logic [VSUM_W-1:0]   vsum_t;
  typedef logic [WIN_W-1:0]    win_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  typedef struct packed {
    prod_t   product;
    volume_t volume;
  } ring_entry_t;

endpackage

`default_nettype wire

/* src/volume_weighted_window_average_top.sv */
// ----------------------------------------------------------------------------
// volume_weighted_window_average_top
// Windowed volume weighted average price with a shared iterative divider.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------
//   in       | in_valid / in_ready  | in_price[23:0], in_volume[31:0]
//   out      | out_valid / out_ready| out_average[23:0], out_ready_res
//   cfg      | cfg_we               | cfg_wdata[8:0] (window_size)
//
// A transaction runs through these steps from acceptance to result: multiply and
// ring read, sum update, the radix-2 divider, then divider done and output
// load. A new transaction is taken only once the block is back in idle.
// Synchronous active-low reset; window_size resets to 20, sums and counts
// clear. A cfg write clears sums, slot and fill count and holds off input.
// A stalled result holds in the output register; the next transaction still
// runs and waits in its last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_weighted_window_average_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire vwwa_pkg::price_t  in_price,
  input  wire vwwa_pkg::volume_t in_volume,
  output logic                   out_valid,
  input  wire                    out_ready,
  output vwwa_pkg::price_t       out_average,
  output logic                   out_ready_res,
  input  wire                    cfg_we,
  input  wire vwwa_pkg::win_t    cfg_wdata
);
  import vwwa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  win_t        window_r, window_nxt;
  psum_t       psum_r, psum_nxt;
  vsum_t       vsum_r, vsum_nxt;
  slot_t       write_slot_r, write_slot_nxt;
  win_t        fill_r, fill_nxt;
  slot_t       slot_r, slot_nxt;
  price_t      price_r, price_nxt;
  volume_t     volume_r, volume_nxt;
  prod_t       product_r, product_nxt;
  logic        res_ready_r, res_ready_nxt;
  logic        vzero_r, vzero_nxt;
  logic        out_valid_r, out_valid_nxt;
  price_t      out_average_r, out_average_nxt;
  logic        out_ready_res_r, out_ready_res_nxt;

  win_t        w_eff;
  slot_t       slot_start;
  logic        full;
  win_t        slot_inc;
  win_t        fill_upd;
  psum_t       psum_upd;
  vsum_t       vsum_upd;
  ring_entry_t rd_data;
  ring_entry_t wr_data;
  logic        div_start;
  logic        div_done;
  psum_t       div_quot;

  always_comb begin
    priority if (window_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(WINDOW_MAX)) begin
      w_eff = WIN_W'(WINDOW_MAX);
    end else begin
      w_eff = window_r;
    end
  end

  assign slot_start = ({1'b0, write_slot_r} >= w_eff) ? '0 : write_slot_r;
  assign full       = fill_r >= w_eff;
  assign slot_inc   = {1'b0, slot_r} + WIN_W'(1);
  assign fill_upd   = full ? fill_r : fill_r + WIN_W'(1);
  assign psum_upd   = psum_r - (full ? PSUM_W'(rd_data.product) : '0)
                      + PSUM_W'(product_r);
  assign vsum_upd   = vsum_r - (full ? VSUM_W'(rd_data.volume) : '0)
                      + VSUM_W'(volume_r);
  assign wr_data    = '{product: product_r, volume: volume_r};
  assign div_start  = state_r == ST_UPD;

  assign in_ready = (state_r == ST_IDLE) && !cfg_we;

  always_comb begin
    state_nxt         = state_r;
    window_nxt        = window_r;
    psum_nxt          = psum_r;
    vsum_nxt          = vsum_r;
    write_slot_nxt    = write_slot_r;
    fill_nxt          = fill_r;
    slot_nxt          = slot_r;
    price_nxt         = price_r;
    volume_nxt        = volume_r;
    product_nxt       = product_r;
    res_ready_nxt     = res_ready_r;
    vzero_nxt         = vzero_r;
    out_valid_nxt     = out_valid_r;
    out_average_nxt   = out_average_r;
    out_ready_res_nxt = out_ready_res_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          window_nxt     = cfg_wdata;
          psum_nxt       = '0;
          vsum_nxt       = '0;
          write_slot_nxt = '0;
          fill_nxt       = '0;
        end else if (in_valid) begin
          price_nxt  = in_price;
          volume_nxt = in_volume;
          slot_nxt   = slot_start;
          state_nxt  = ST_MUL;
        end
      end
      ST_MUL: begin
        product_nxt = PROD_W'(price_r) * PROD_W'(volume_r);
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        psum_nxt       = psum_upd;
        vsum_nxt       = vsum_upd;
        write_slot_nxt = (slot_inc >= w_eff) ? '0 : slot_inc[SLOT_W-1:0];
        fill_nxt       = fill_upd;
        res_ready_nxt  = fill_upd >= w_eff;
        vzero_nxt      = vsum_upd == '0;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt     = 1'b1;
          out_average_nxt   = (res_ready_r && !vzero_r) ? div_quot[PRICE_W-1:0] : '0;
          out_ready_res_nxt = res_ready_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      window_r     <= WIN_W'(WINDOW_RESET);
      psum_r       <= '0;
      vsum_r       <= '0;
      write_slot_r <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      window_r     <= window_nxt;
      psum_r       <= psum_nxt;
      vsum_r       <= vsum_nxt;
      write_slot_r <= write_slot_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r          <= slot_nxt;
    price_r         <= price_nxt;
    volume_r        <= volume_nxt;
    product_r       <= product_nxt;
    res_ready_r     <= res_ready_nxt;
    vzero_r         <= vzero_nxt;
    out_average_r   <= out_average_nxt;
    out_ready_res_r <= out_ready_res_nxt;
  end

  vwwa_ring u_ring (
    .clk     (clk),
    .wr_en   (state_r == ST_UPD),
    .wr_addr (slot_r),
    .wr_data (wr_data),
    .rd_en   (state_r == ST_MUL),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  vwwa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (psum_upd),
    .divisor  (vsum_upd),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid     = out_valid_r;
  assign out_average   = out_average_r;
  assign out_ready_res = out_ready_res_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count beyond window");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, write_slot_r} < w_eff)
    else $error("write slot outside window");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready_res_r) |-> (out_average_r == '0))
    else $error("average nonzero while window filling");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide phase");
`endif

endmodule

`default_nettype wire

/* src/vwwa_ring.sv */
// ----------------------------------------------------------------------------
// vwwa_ring
// Single-port-write, registered-read ring of product and volume entries.
// ----------------------------------------------------------------------------
`default_nettype none

module vwwa_ring (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire vwwa_pkg::slot_t   wr_addr,
  input  wire vwwa_pkg::ring_entry_t wr_data,
  input  wire                    rd_en,
  input  wire vwwa_pkg::slot_t   rd_addr,
  output vwwa_pkg::ring_entry_t  rd_data
);
  import vwwa_pkg::*;

  ring_entry_t mem [0:WINDOW_MAX-1];
  ring_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/vwwa_div.sv */
// ----------------------------------------------------------------------------
// vwwa_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vwwa_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire vwwa_pkg::psum_t dividend,
  input  wire vwwa_pkg::vsum_t divisor,
  output logic                 done,
  output vwwa_pkg::psum_t      quotient
);
  import vwwa_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  vsum_t                rem_r, rem_nxt;
  psum_t                dq_r, dq_nxt;
  vsum_t                dvs_r, dvs_nxt;
  logic [VSUM_W:0]      rem_sh;
  logic [VSUM_W:0]      diff;
  logic                 ge;

  assign rem_sh = {rem_r, dq_r[PSUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[VSUM_W-1:0] : rem_sh[VSUM_W-1:0];
      dq_nxt  = {dq_r[PSUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == {DIV_CNT_W{1'b1}}) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

`default_nettype wire

/* test/tb_volume_weighted_window_average_top.sv */
// ----------------------------------------------------------------------------
// tb_volume_weighted_window_average_top
// Self-checking bench for the windowed volume weighted average price block.
// A queue-fed driver sends bars with random gaps, and a monitor with random
// back-pressure compares every result against an in-bench model of the
// ring and running sums. The window size is swept through its extremes,
// out-of-range codes included, with all state cleared at each write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_volume_weighted_window_average_top;
  import vwwa_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_MAX   = 40;

  typedef struct {
    price_t  price;
    volume_t volume;
  } bar_t;

  typedef struct {
    price_t average;
    logic   ready_res;
  } vwap_res_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  price_t  in_price = '0;
  volume_t in_volume = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  price_t  out_average;
  logic    out_ready_res;
  logic    cfg_we = 1'b0;
  win_t    cfg_wdata = '0;

  bar_t      bar_q[$];
  vwap_res_t vwap_q[$];
  int        err_cnt = 0;
  int        cycle_cnt = 0;
  int        in_gap = 0;
  int        out_stall = 0;
  bit        in_gaps_on = 1'b0;
  bit        out_stalls_on = 1'b0;

  // Window model
  win_t    win_reg;
  prod_t   prod_ring[WINDOW_MAX];
  volume_t vol_ring[WINDOW_MAX];
  psum_t   prod_acc;
  vsum_t   vol_acc;
  int      slot_ptr;
  int      fill_cnt;

  volume_weighted_window_average_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_price     (in_price),
    .in_volume    (in_volume),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_average  (out_average),
    .out_ready_res(out_ready_res),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic vwap_clear(win_t w);
    win_reg  = w;
    prod_acc = '0;
    vol_acc  = '0;
    slot_ptr = 0;
    fill_cnt = 0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      prod_ring[i] = '0;
      vol_ring[i]  = '0;
    end
  endtask

  task automatic vwap_advance(price_t p, volume_t v);
    prod_t     prod;
    psum_t     quot;
    int        w;
    int        s;
    vwap_res_t r;
    prod = p * v;
    w = (win_reg == 0) ? 1 : ((win_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
    s = (slot_ptr >= w) ? 0 : slot_ptr;
    if (fill_cnt >= w) begin
      prod_acc -= prod_ring[s];
      vol_acc  -= vol_ring[s];
    end
    prod_ring[s] = prod;
    vol_ring[s]  = v;
    prod_acc += prod;
    vol_acc  += v;
    s++;
    slot_ptr = (s >= w) ? 0 : s;
    if (fill_cnt < w) fill_cnt++;
    r.ready_res = (fill_cnt >= w);
    r.average   = '0;
    if (r.ready_res && vol_acc != 0) begin
      quot = prod_acc / vol_acc;
      r.average = quot[PRICE_W-1:0];
    end
    vwap_q.insert(vwap_q.size(), r);
  endtask

  task automatic report_mismatch(string msg);
    if (err_cnt < PRINT_MAX) $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  // Driver
  always @(posedge clk) begin
    bit holding;
    bar_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
      vwap_clear(win_t'(WINDOW_RESET));
    end else begin
      holding = in_valid && !in_ready;
      if (cfg_we) vwap_clear(cfg_wdata);
      if (in_valid && in_ready) vwap_advance(in_price, in_volume);
      if (!holding) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (bar_q.size() > 0) begin
          b = bar_q[0];
          bar_q.delete(0);
          in_valid  <= 1'b1;
          in_price  <= b.price;
          in_volume <= b.volume;
          in_gap = in_gaps_on ? int'($urandom_range(0, 7)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    vwap_res_t r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (vwap_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result avg=%0h rdy=%0b",
                                    out_average, out_ready_res));
        end else begin
          r = vwap_q[0];
          vwap_q.delete(0);
          if (out_average !== r.average)
            report_mismatch($sformatf("average got %0h exp %0h", out_average, r.average));
          if (out_ready_res !== r.ready_res)
            report_mismatch($sformatf("ready_res got %0b exp %0b",
                                      out_ready_res, r.ready_res));
        end
        out_stall = out_stalls_on ? int'($urandom_range(0, 7)) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk);
    while (bar_q.size() != 0 || in_valid || vwap_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(win_t w);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    in_gaps_on    = ($urandom_range(0, 3) != 0);
    out_stalls_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic add_bar(price_t p, volume_t v);
    bar_t b;
    b.price  = p;
    b.volume = v;
    bar_q.insert(bar_q.size(), b);
  endtask

  task automatic add_random(int n);
    price_t  p;
    volume_t v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       p = '0;
        1:       p = '1;
        2:       p = price_t'($urandom_range(0, 255));
        default: p = price_t'($urandom());
      endcase
      case ($urandom_range(0, 7))
        0, 1:    v = '0;
        2:       v = '1;
        3:       v = volume_t'($urandom_range(0, 15));
        default: v = volume_t'($urandom());
      endcase
      add_bar(p, v);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Default window of 20: fill, then wrap once
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    add_bar('1, '1);
    add_bar('0, '1);
    add_bar('1, '0);
    add_bar('0, '0);
    add_bar(price_t'(24'h000100), volume_t'(1));
    add_bar(price_t'(24'h800000), volume_t'(32'h8000_0000));
    for (int i = 0; i < 14; i++) add_bar('1, '1);
    add_bar(price_t'(24'h000001), volume_t'(32'h0000_0001));

    // Window of one: zero volume sum, then extremes
    set_window(win_t'(1));
    add_bar('1, '0);
    add_bar('1, '1);
    add_bar('0, '1);
    add_bar(price_t'(1), volume_t'(1));

    set_window(win_t'(0));
    add_random(40);
    set_window(win_t'(2));
    add_random(60);
    set_window(win_t'(WINDOW_MAX));
    add_random(300);
    set_window(win_t'(1));
    add_random(50);
    set_window(win_t'(511));
    add_random(60);
    for (int k = 0; k < 4; k++) begin
      set_window(win_t'($urandom_range(3, 40)));
      add_random(75);
    end
    set_window(win_t'(300));
    add_random(30);
    set_window(win_t'(WINDOW_RESET));
    add_random(100);
    set_window(win_t'(257));
    add_random(20);
    for (int k = 0; k < 2; k++) begin
      set_window(win_t'($urandom_range(1, 16)));
      add_random(100);
    end

    wait_drained();
    repeat (100) @(negedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
